// File: rtl/sam_pkg.sv
// Package for the sensor alert monitor: rule and item types, kind codes,
// stream widths and the value sign-extension helper.
// No dependencies; every other file imports it.
package sam_pkg;

    // Field widths fixed by the stream format
    localparam int SENSOR_W    = 8;
    localparam int STAMP_W     = 32;
    localparam int VALUE_W     = 32;
    localparam int SLOT_W      = 2;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 42;

    // Stream bus widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 2;

    // At most this many alerts leave per reading
    localparam int MAX_ALERTS  = 4;
    localparam int ALERT_CNT_W = 3;

    // Rule kinds (bits 1:0 of a rule register)
    localparam logic [1:0] RULE_OFF   = 2'd0;
    localparam logic [1:0] RULE_ABOVE = 2'd1;
    localparam logic [1:0] RULE_BELOW = 2'd2;
    localparam logic [1:0] RULE_STUCK = 2'd3;

    // Alert kinds
    localparam logic [KIND_W-1:0] ALERT_ABOVE = 2'd0;
    localparam logic [KIND_W-1:0] ALERT_BELOW = 2'd1;
    localparam logic [KIND_W-1:0] ALERT_STUCK = 2'd2;

    // Packed rule: kind in the low bits, threshold/window at the top
    typedef struct packed {
        logic [VALUE_W-1:0]  threshold;
        logic [SENSOR_W-1:0] sensor;
        logic [1:0]          kind;
    } rule_t;

    // One reading after capture; value already sign-extended
    typedef struct packed {
        logic [SENSOR_W-1:0]       sensor;
        logic [STAMP_W-1:0]        stamp;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    // Emitter status seen by the front end
    typedef struct packed {
        logic busy;   // a reading's alerts are still being sent
        logic free;   // pending slot can take a new reading this cycle
    } emit_status_t;

    // Sign-extend the low (VALUE_W - shift) bits of v to the full width
    function automatic logic signed [VALUE_W-1:0] sext_value(
        input logic [VALUE_W-1:0] v,
        input int unsigned        shift
    );
        logic signed [VALUE_W-1:0] t;
        t = $signed(v << shift);
        return t >>> shift;
    endfunction

endpackage

// File: rtl/sam_rule_eval.sv
// Rule evaluation for the sensor alert monitor: per-slot run tracking state
// and the fire mask of the reading held in the input register.
// Depends on sam_pkg.
module sam_rule_eval import sam_pkg::*; #(
    parameter int RULE_COUNT = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  item_t                 item,
    input  logic                  bad,
    input  logic                  commit,
    input  rule_t [RULE_COUNT-1:0] rules,
    input  logic [RULE_COUNT-1:0] clear,
    output logic [RULE_COUNT-1:0] fire_mask
);

    localparam int unsigned SHIFT = VALUE_W - VALUE_BITS;

    logic [VALUE_BITS-1:0] prev_reg [RULE_COUNT];
    logic [VALUE_W-1:0]    run_reg  [RULE_COUNT];
    logic [RULE_COUNT-1:0] fire;

    for (genvar i = 0; i < RULE_COUNT; i++) begin : g_lane
        logic                      match;
        logic                      same;
        logic [VALUE_W-1:0]        run_next;
        logic signed [VALUE_W-1:0] th;

        assign match = (rules[i].sensor == item.sensor);
        assign same  = (run_reg[i] != '0) && (prev_reg[i] == item.value[VALUE_BITS-1:0]);
        assign th    = sext_value(rules[i].threshold, SHIFT);

        // Run length including this reading, saturating
        always_comb begin
            if (!same) begin
                run_next = VALUE_W'(1);
            end else if (run_reg[i] == '1) begin
                run_next = run_reg[i];
            end else begin
                run_next = run_reg[i] + VALUE_W'(1);
            end
        end

        // Fire decision per rule kind
        always_comb begin
            case (rules[i].kind)
                RULE_OFF:   fire[i] = 1'b0;
                RULE_ABOVE: fire[i] = item.value > th;
                RULE_BELOW: fire[i] = item.value < th;
                RULE_STUCK: fire[i] = !rules[i].threshold[VALUE_W-1]
                                      && (rules[i].threshold != '0)
                                      && (run_next >= rules[i].threshold);
                default:    fire[i] = 1'b0;
            endcase
            fire[i] = fire[i] && match && !bad;
        end

        // Run state: cleared on a rule write, updated on every matching reading
        always_ff @(posedge aclk) begin
            if (!aresetn || clear[i]) begin
                prev_reg[i] <= '0;
                run_reg[i]  <= '0;
            end else if (commit && match) begin
                prev_reg[i] <= item.value[VALUE_BITS-1:0];
                run_reg[i]  <= run_next;
            end
        end
    end

    // Keep only the first MAX_ALERTS firing rules in slot order
    always_comb begin
        logic [ALERT_CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < RULE_COUNT; i++) begin
            fire_mask[i] = fire[i] && (cnt < ALERT_CNT_W'(MAX_ALERTS));
            if (fire_mask[i]) begin
                cnt = cnt + ALERT_CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/sam_alert_emit.sv
// Alert emitter for the sensor alert monitor: holds one reading's fire mask
// and sends one alert per cycle while m_tready is high, in slot order, through an output register.
// Depends on sam_pkg.
module sam_alert_emit import sam_pkg::*; #(
    parameter int RULE_COUNT = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  item_t                  item,
    input  logic [RULE_COUNT-1:0]  fire_mask,
    input  rule_t [RULE_COUNT-1:0] rules,
    output emit_status_t           status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic [M_TUSER_W-1:0]   m_tuser,
    output logic                   m_tlast
);

    localparam int unsigned SHIFT = VALUE_W - VALUE_BITS;

    logic                  busy_reg;
    logic [RULE_COUNT-1:0] mask_reg;
    item_t                 item_reg;

    logic                  out_valid_reg;
    logic [SENSOR_W-1:0]   out_sensor_reg;
    logic [STAMP_W-1:0]    out_stamp_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [KIND_W-1:0]     out_kind_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [VALUE_W-1:0]    out_limit_reg;
    logic                  out_last_reg;

    logic                  can_emit;
    logic [RULE_COUNT-1:0] mask_next;
    logic                  last;
    rule_t                 sel_rule;
    logic [SLOT_W-1:0]     sel_slot;
    logic [KIND_W-1:0]     sel_kind;
    logic [VALUE_W-1:0]    sel_limit;

    // Lowest pending slot goes first
    always_comb begin
        logic found;
        found     = 1'b0;
        sel_rule  = rules[0];
        sel_slot  = '0;
        mask_next = mask_reg;
        for (int i = 0; i < RULE_COUNT; i++) begin
            if (!found && mask_reg[i]) begin
                found        = 1'b1;
                sel_rule     = rules[i];
                sel_slot     = SLOT_W'(i);
                mask_next[i] = 1'b0;
            end
        end
    end

    // Alert kind and reported limit from the selected rule
    always_comb begin
        case (sel_rule.kind)
            RULE_BELOW: begin
                sel_kind  = ALERT_BELOW;
                sel_limit = sext_value(sel_rule.threshold, SHIFT);
            end
            RULE_STUCK: begin
                sel_kind  = ALERT_STUCK;
                sel_limit = sel_rule.threshold;
            end
            default: begin
                sel_kind  = ALERT_ABOVE;
                sel_limit = sext_value(sel_rule.threshold, SHIFT);
            end
        endcase
    end

    assign can_emit    = busy_reg && (!out_valid_reg || m_tready);
    assign last        = (mask_next == '0);
    assign status.busy = busy_reg;
    assign status.free = !busy_reg || (can_emit && last);

    // Pending reading
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= 1'b1;
        end else if (can_emit && last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mask_reg <= fire_mask;
            item_reg <= item;
        end else if (can_emit) begin
            mask_reg <= mask_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (can_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_emit) begin
            out_sensor_reg <= item_reg.sensor;
            out_stamp_reg  <= item_reg.stamp;
            out_slot_reg   <= sel_slot;
            out_kind_reg   <= sel_kind;
            out_value_reg  <= item_reg.value;
            out_limit_reg  <= sel_limit;
            out_last_reg   <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_limit_reg, out_value_reg, out_slot_reg,
                       out_stamp_reg, out_sensor_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/sensor_alert_monitor_unit.sv
// Sensor alert monitor top level. An accepted reading passes the input register
// and the emitter's pending register; its first alert then leaves the output
// register on m_tvalid. Alerts follow one a cycle (up to 4) while m_tready is
// high, set by the single output register; a reading with no alert never waits on the emitter.
// Reset (aresetn low, synchronous) clears the rules, run state and all valids.
// Depends on sam_pkg, sam_rule_eval and sam_alert_emit.
module sensor_alert_monitor_unit import sam_pkg::*; #(
    parameter int RULE_COUNT = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Reading stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // sensor[7:0], stamp[39:8], reading[71:40]
    input  logic                   s_tuser,   // bad_quality
    // Alert stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // alert_sensor[7:0], alert_stamp[39:8],
                                              // rule_slot[41:40], alert_value[73:42],
                                              // limit[105:74], zero[111:106]
    output logic [M_TUSER_W-1:0]   m_tuser,   // alert_kind[1:0]
    output logic                   m_tlast,   // final_res
    // Rule configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned SHIFT = VALUE_W - VALUE_BITS;

    rule_t [RULE_COUNT-1:0] rule_reg;
    logic [RULE_COUNT-1:0]  cfg_clear;

    logic                  in_valid_reg;
    item_t                 in_item_reg;
    logic                  in_bad_reg;

    logic [RULE_COUNT-1:0] eval_mask;
    emit_status_t          emit_stat;
    logic                  in_go;
    logic                  load;

    // Rule registers
    assign cfg_ready = 1'b1;

    for (genvar i = 0; i < RULE_COUNT; i++) begin : g_rule
        assign cfg_clear[i] = cfg_valid && (cfg_index == CFG_INDEX_W'(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rule_reg[i] <= '0;
            end else if (cfg_clear[i]) begin
                rule_reg[i] <= rule_t'(cfg_data);
            end
        end
    end

    // Input register: a reading leaves once its alerts have a place to go
    assign in_go    = in_valid_reg && ((eval_mask == '0) || emit_stat.free);
    assign load     = in_go && (eval_mask != '0);
    assign s_tready = !in_valid_reg || in_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.sensor <= s_tdata[7:0];
            in_item_reg.stamp  <= s_tdata[39:8];
            in_item_reg.value  <= sext_value(s_tdata[71:40], SHIFT);
            in_bad_reg         <= s_tuser;
        end
    end

    sam_rule_eval #(
        .RULE_COUNT (RULE_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (in_item_reg),
        .bad       (in_bad_reg),
        .commit    (in_go),
        .rules     (rule_reg),
        .clear     (cfg_clear),
        .fire_mask (eval_mask)
    );

    sam_alert_emit #(
        .RULE_COUNT (RULE_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .item      (in_item_reg),
        .fire_mask (eval_mask),
        .rules     (rule_reg),
        .status    (emit_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // No reading may ask for more alerts than one result group holds
    a_alert_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> $countones(eval_mask) <= MAX_ALERTS)
        else $error("fire mask exceeds alert cap");

    // A reading with alerts always lands in the emitter
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> emit_stat.busy)
        else $error("loaded reading not pending");

    // Back-pressure only while a held reading is blocked by the emitter
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && emit_stat.busy && !emit_stat.free)
        else $error("input stalled without cause");

endmodule
